// ===== design/dbs_pkg.sv =====
`timescale 1ns / 1ps

package dbs_pkg;

    // One input transfer: a scored item and the end-of-list mark.
    typedef struct packed {
        logic [7:0]  score;
        logic [23:0] payload;
        logic        final_item;
    } in_t;

    // One result transfer.
    typedef struct packed {
        logic [7:0]  sorted_score;
        logic [23:0] sorted_payload;
        logic        end_of_list;
    } out_t;

    // One stored entry of the item memory.
    typedef struct packed {
        logic [7:0]  score;
        logic [23:0] payload;
    } item_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_START,
        ST_PASS_LOAD,
        ST_PASS_RUN,
        ST_PASS_END,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic list_start;
        logic pass_start;
        logic pass_load;
        logic pass_run;
        logic pass_end;
        logic emit_load;
        logic list_done;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic run_last;
        logic sort_done;
        logic last_out;
    } status_t;

endpackage

// ===== design/dbs_ctrl.sv =====
`timescale 1ns / 1ps

module dbs_ctrl
    import dbs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_final,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    if (s_final) begin
                        cmd.list_start = 1'b1;
                        // A list of one item needs no sorting.
                        state_next = status.count_zero ? ST_EMIT_RD : ST_PASS_START;
                    end
                end
            end
            ST_PASS_START: begin
                cmd.pass_start = 1'b1;
                state_next     = ST_PASS_LOAD;
            end
            ST_PASS_LOAD: begin
                cmd.pass_load = 1'b1;
                state_next    = ST_PASS_RUN;
            end
            ST_PASS_RUN: begin
                cmd.pass_run = 1'b1;
                if (status.run_last) begin
                    state_next = ST_PASS_END;
                end
            end
            ST_PASS_END: begin
                cmd.pass_end = 1'b1;
                state_next   = status.sort_done ? ST_EMIT_RD : ST_PASS_START;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                cmd.emit_load = 1'b1;
                state_next    = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.last_out) begin
                        cmd.list_done = 1'b1;
                        state_next    = ST_LOAD;
                    end else begin
                        state_next = ST_EMIT_LD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== design/dbs_datapath.sv =====
`timescale 1ns / 1ps

module dbs_datapath
    import dbs_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  in_t     s_data,
    output out_t    m_data,
    input  cmd_t    cmd,
    output status_t status
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    item_t mem [MAX_ITEMS];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic             swapped_reg;
    item_t            rdata_reg;
    item_t            carry_reg;
    out_t             out_reg;

    logic             not_full;
    logic             swap;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    item_t            mem_wdata;
    item_t            in_item;

    assign not_full      = count_reg < CNT_W'(MAX_ITEMS);
    assign in_item.score   = s_data.score;
    assign in_item.payload = s_data.payload;

    // The later item moves ahead only on a strictly greater score.
    assign swap = rdata_reg.score > carry_reg.score;

    // Write port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = in_item;
        if (cmd.load_item) begin
            mem_we = not_full;
        end else if (cmd.pass_run) begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_reg;
            mem_wdata = swap ? rdata_reg : carry_reg;
        end else if (cmd.pass_end) begin
            mem_we    = 1'b1;
            mem_waddr = last_idx_reg;
            mem_wdata = carry_reg;
        end
    end

    // Item memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
    end

    // Item count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.list_done) begin
            count_reg <= '0;
        end else if (cmd.load_item && not_full) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Pass pointers, bubbling item and swap flag.
    always_ff @(posedge aclk) begin
        if (cmd.list_start) begin
            rd_ptr_reg   <= '0;
            last_idx_reg <= not_full ? count_reg[IDX_W-1:0] : IDX_W'(MAX_ITEMS - 1);
        end
        if (cmd.pass_start) begin
            rd_ptr_reg  <= rd_ptr_reg + CNT_W'(1);
            wr_ptr_reg  <= '0;
            swapped_reg <= 1'b0;
        end
        if (cmd.pass_load) begin
            rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            carry_reg  <= rdata_reg;
        end
        if (cmd.pass_run) begin
            rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            wr_ptr_reg <= wr_ptr_reg + IDX_W'(1);
            if (swap) begin
                swapped_reg <= 1'b1;
            end else begin
                carry_reg <= rdata_reg;
            end
        end
        if (cmd.pass_end) begin
            rd_ptr_reg <= '0;
            if (!status.sort_done) begin
                last_idx_reg <= last_idx_reg - IDX_W'(1);
            end
        end
        if (cmd.emit_load) begin
            rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_reg.sorted_score   <= rdata_reg.score;
            out_reg.sorted_payload <= rdata_reg.payload;
            out_reg.end_of_list    <= (rd_ptr_reg + CNT_W'(1)) == count_reg;
        end
    end

    assign m_data = out_reg;

    // Status toward the controller.
    assign status.count_zero = count_reg == '0;
    assign status.run_last   = ({1'b0, wr_ptr_reg} + (IDX_W + 1)'(1)) == {1'b0, last_idx_reg};
    assign status.sort_done  = !swapped_reg || (last_idx_reg == IDX_W'(1));
    assign status.last_out   = out_reg.end_of_list;

endmodule

// ===== design/descending_bubble_sort.sv =====
`timescale 1ns / 1ps
// The block takes one input transfer per cycle while it is loading and s_ready is high. With n
// items in the list, each sort pass over the first m items runs on one compare-swap unit that
// streams the item memory through its single read and single write port; up to n - 1 passes
// run, fewer when a pass makes no swap. Results are then read out one at a time through the
// output register, each held until m_ready takes it. Reset (aresetn, synchronous, active
// low) empties the list and returns the block to loading.

module descending_bubble_sort
    import dbs_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t    cmd;
    status_t status;

    // Sequencing of load, sort passes and result transfers.
    dbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_final (s_data.final_item),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Item memory, compare-swap unit and output register.
    dbs_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule
